[hdl/bto_pkg.sv]
// Shared types, constants and font table for the box and timestamp overlay.
package bto_pkg;

    // Text buffer depth and derived widths.
    localparam int MAX_TEXT_CHARS = 32;
    localparam int IDX_W  = (MAX_TEXT_CHARS > 1) ? $clog2(MAX_TEXT_CHARS) : 1;
    localparam int CI_W   = $clog2(MAX_TEXT_CHARS + 1);
    // Horizontal offset into the glyph row, only meaningful inside the panel.
    localparam int DX_W   = $clog2(12 * MAX_TEXT_CHARS + 2);
    // Fixed-point reciprocal of the 12-pixel character pitch.
    localparam int RECIP_SH = DX_W + 6;
    localparam int RECIP_W  = RECIP_SH - 2;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** RECIP_SH) + 11) / 12);
    // Compare width for the panel right edge (12 * MAX + 10 stays below 4096).
    localparam int XCMP_W = 12;

    // Configuration register indexes.
    localparam logic [7:0] REG_BOX_ENABLE   = 8'd0;
    localparam logic [7:0] REG_BOX_LEFT     = 8'd1;
    localparam logic [7:0] REG_BOX_TOP      = 8'd2;
    localparam logic [7:0] REG_BOX_RIGHT    = 8'd3;
    localparam logic [7:0] REG_BOX_BOTTOM   = 8'd4;
    localparam logic [7:0] REG_FRAME_WIDTH  = 8'd5;
    localparam logic [7:0] REG_FRAME_HEIGHT = 8'd6;
    localparam logic [7:0] REG_TEXT_LENGTH  = 8'd7;

    // Result source codes.
    localparam logic [1:0] SRC_PASS  = 2'd0;
    localparam logic [1:0] SRC_BOX   = 2'd1;
    localparam logic [1:0] SRC_PANEL = 2'd2;
    localparam logic [1:0] SRC_GLYPH = 2'd3;

    // Colors.
    localparam logic [15:0] COLOR_RED   = 16'hF800;
    localparam logic [15:0] COLOR_WHITE = 16'hFFFF;
    localparam logic [15:0] COLOR_BLACK = 16'h0000;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [3:0] GLYPH_DASH  = 4'd10;
    localparam logic [3:0] GLYPH_COLON = 4'd11;
    localparam logic [3:0] GLYPH_BLANK = 4'd12;

    typedef struct packed {
        logic               box_enable;
        logic signed [11:0] box_left;
        logic signed [11:0] box_top;
        logic signed [11:0] box_right;
        logic signed [11:0] box_bottom;
        logic [10:0]        frame_width;
        logic [10:0]        frame_height;
        logic [5:0]         text_length;
    } cfg_t;

    typedef logic [4:0] font_row_t;

    // 5x7 font, MSB is the leftmost column.
    localparam font_row_t FONT [0:12][0:6] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
    };

    // Map a character code to its font entry; anything unknown is blank.
    function automatic logic [3:0] glyph_index(input logic [7:0] code);
        logic [7:0] diff;
        begin
            diff = code - CH_ZERO;
            if (code >= CH_ZERO && code <= CH_NINE) begin
                glyph_index = diff[3:0];
            end else if (code == CH_DASH) begin
                glyph_index = GLYPH_DASH;
            end else if (code == CH_COLON) begin
                glyph_index = GLYPH_COLON;
            end else begin
                glyph_index = GLYPH_BLANK;
            end
        end
    endfunction

endpackage

[hdl/bto_cfg_regs.sv]
// Configuration register file for the overlay.
module bto_cfg_regs (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output bto_pkg::cfg_t cfg
);
    import bto_pkg::*;

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.box_enable   <= 1'b0;
            cfg_reg.box_left     <= '0;
            cfg_reg.box_top      <= '0;
            cfg_reg.box_right    <= '0;
            cfg_reg.box_bottom   <= '0;
            cfg_reg.frame_width  <= 11'd320;
            cfg_reg.frame_height <= 11'd240;
            cfg_reg.text_length  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BOX_ENABLE:   cfg_reg.box_enable   <= cfg_data[0];
                REG_BOX_LEFT:     cfg_reg.box_left     <= signed'(cfg_data[11:0]);
                REG_BOX_TOP:      cfg_reg.box_top      <= signed'(cfg_data[11:0]);
                REG_BOX_RIGHT:    cfg_reg.box_right    <= signed'(cfg_data[11:0]);
                REG_BOX_BOTTOM:   cfg_reg.box_bottom   <= signed'(cfg_data[11:0]);
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[10:0];
                REG_TEXT_LENGTH:  cfg_reg.text_length  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

endmodule

[hdl/bto_text_store.sv]
// Timestamp character buffer: one write port, one combinational read port.
module bto_text_store (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [4:0]            wr_slot,
    input  logic [7:0]            wr_code,
    input  logic [bto_pkg::IDX_W-1:0] rd_idx,
    output logic [7:0]            rd_code
);
    import bto_pkg::*;

    logic [7:0] chars_reg [MAX_TEXT_CHARS];
    logic       slot_ok;

    // Drop stores beyond the buffer depth.
    assign slot_ok = 32'(wr_slot) < MAX_TEXT_CHARS;
    assign rd_code = chars_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TEXT_CHARS; i++) begin
                chars_reg[i] <= CH_SPACE;
            end
        end else if (wr_en && slot_ok) begin
            chars_reg[IDX_W'(wr_slot)] <= wr_code;
        end
    end

endmodule

[hdl/bto_shade.sv]
// Per-pixel recolor logic: box outline, text panel and glyph lookup.
module bto_shade (
    input  bto_pkg::cfg_t             cfg,
    input  logic [10:0]               pixel_x,
    input  logic [10:0]               pixel_y,
    input  logic [15:0]               pixel_color,
    output logic [bto_pkg::IDX_W-1:0] rd_idx,
    input  logic [7:0]                rd_code,
    output logic [15:0]               out_color,
    output logic [1:0]                source
);
    import bto_pkg::*;

    logic signed [12:0] xs, ys, l, r, t, b, lo_x, hi_x, lo_y, hi_y;
    logic               in_outer, in_inner, box_hit, in_frame;
    logic [CI_W-1:0]    len_sat;
    logic [10:0]        py, yrel;
    logic [XCMP_W-1:0]  xlim;
    logic               panel_hit, row_ok;
    logic [10:0]        dx_full;
    logic [DX_W-1:0]    dx, cx;
    logic [DX_W+RECIP_W-1:0] prod;
    logic [CI_W-1:0]    ci;
    logic [DX_W-1:0]    ci_x12;
    logic [10:0]        dy;
    logic [2:0]         row, col;
    logic [3:0]         gidx;
    font_row_t          bits;
    logic               glyph_hit;

    assign in_frame = (pixel_x < cfg.frame_width) && (pixel_y < cfg.frame_height);

    // Box: sort corners, then outer-expanded minus strict interior.
    assign xs = signed'({2'b00, pixel_x});
    assign ys = signed'({2'b00, pixel_y});
    assign l  = 13'(cfg.box_left);
    assign r  = 13'(cfg.box_right);
    assign t  = 13'(cfg.box_top);
    assign b  = 13'(cfg.box_bottom);
    assign lo_x = (l > r) ? r : l;
    assign hi_x = (l > r) ? l : r;
    assign lo_y = (t > b) ? b : t;
    assign hi_y = (t > b) ? t : b;
    assign in_outer = (xs >= lo_x - 13'sd1) && (xs <= hi_x + 13'sd1) &&
                      (ys >= lo_y - 13'sd1) && (ys <= hi_y + 13'sd1);
    assign in_inner = (xs > lo_x) && (xs < hi_x) && (ys > lo_y) && (ys < hi_y);
    assign box_hit  = cfg.box_enable && in_outer && !in_inner;

    // Text panel geometry.
    assign len_sat = (7'(cfg.text_length) > 7'(MAX_TEXT_CHARS)) ?
                     CI_W'(MAX_TEXT_CHARS) : CI_W'(cfg.text_length);
    assign py   = (cfg.frame_height >= 11'd22) ? cfg.frame_height - 11'd22 : '0;
    assign yrel = pixel_y - py;
    assign xlim = XCMP_W'(len_sat) * XCMP_W'(12) + XCMP_W'(10);
    assign panel_hit = (len_sat != '0) && (pixel_x >= 11'd4) &&
                       (XCMP_W'(pixel_x) < xlim) &&
                       (pixel_y >= py) && (yrel < 11'd22);

    // Character cell: index by reciprocal multiply, column by remainder.
    assign dx_full = pixel_x - 11'd8;
    assign dx      = dx_full[DX_W-1:0];
    assign prod    = (DX_W+RECIP_W)'(dx) * (DX_W+RECIP_W)'(RECIP);
    assign ci      = prod[RECIP_SH +: CI_W];
    assign ci_x12  = DX_W'({ci, 3'b000}) + DX_W'({ci, 2'b00});
    assign cx      = dx - ci_x12;
    assign col     = cx[3:1];
    assign rd_idx  = IDX_W'(ci);

    assign row_ok = (yrel >= 11'd4) && (yrel < 11'd18);
    assign dy     = yrel - 11'd4;
    assign row    = dy[3:1];

    assign gidx = glyph_index(rd_code);
    assign bits = row_ok ? FONT[gidx][row] : '0;

    assign glyph_hit = panel_hit && (pixel_x >= 11'd8) && row_ok &&
                       (ci < len_sat) && (cx < DX_W'(10)) &&
                       bits[3'd4 - col];

    always_comb begin
        out_color = pixel_color;
        source    = SRC_PASS;
        if (in_frame) begin
            if (glyph_hit) begin
                out_color = COLOR_WHITE;
                source    = SRC_GLYPH;
            end else if (panel_hit) begin
                out_color = COLOR_BLACK;
                source    = SRC_PANEL;
            end else if (box_hit) begin
                out_color = COLOR_RED;
                source    = SRC_BOX;
            end
        end
    end

endmodule

[hdl/box_and_timestamp_overlay.sv]
// Top level of the box and timestamp overlay for an RGB565 pixel stream.
// Path: a pixel transaction is taken into the input register and moves on
// to the output register, which drives m_tvalid, once that register is free.
// Throughput: one item per cycle while m_tready is held high, set by the
// combinational recolor logic between the input register and the output register.
// Reset: aresetn (synchronous, active low) empties both stages, restores the
// register defaults and fills the text buffer with spaces.
module box_and_timestamp_overlay (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pixel_x[10:0], pixel_y[21:11], pixel_color[37:22],
                                   // char_slot[42:38], char_code[50:43], zero pad
    input  logic        s_tuser,   // action (0 pixel, 1 store character)
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_color[15:0]
    output logic [1:0]  m_tuser,   // source[1:0]
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bto_pkg::*;

    cfg_t cfg;

    // Input stage registers.
    logic        in_valid_reg;
    logic        in_action_reg;
    logic [10:0] in_x_reg, in_y_reg;
    logic [15:0] in_color_reg;
    logic [4:0]  in_slot_reg;
    logic [7:0]  in_code_reg;

    // Output stage registers.
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_color_reg;
    logic [1:0]  out_src_reg;

    logic             out_free, in_leave, in_take, store_now;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       rd_code;
    logic [15:0]      shade_color;
    logic [1:0]       shade_src;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    bto_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The output register can load when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // A store leaves the input stage at once; a pixel needs room downstream.
    assign in_leave  = in_valid_reg && (in_action_reg || out_free);
    assign s_tready  = !in_valid_reg || in_leave;
    assign in_take   = s_tvalid && s_tready;
    // Commit the character as the store leaves, so later pixels see it.
    assign store_now = in_valid_reg && in_action_reg;

    bto_text_store u_text (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (store_now),
        .wr_slot (in_slot_reg),
        .wr_code (in_code_reg),
        .rd_idx  (rd_idx),
        .rd_code (rd_code)
    );

    bto_shade u_shade (
        .cfg         (cfg),
        .pixel_x     (in_x_reg),
        .pixel_y     (in_y_reg),
        .pixel_color (in_color_reg),
        .rd_idx      (rd_idx),
        .rd_code     (rd_code),
        .out_color   (shade_color),
        .source      (shade_src)
    );

    // Input stage: hold the transaction until it can move on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (in_leave) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_action_reg <= s_tuser;
            in_x_reg      <= s_tdata[10:0];
            in_y_reg      <= s_tdata[21:11];
            in_color_reg  <= s_tdata[37:22];
            in_slot_reg   <= s_tdata[42:38];
            in_code_reg   <= s_tdata[50:43];
        end
    end

    // Output stage: a pixel leaving the input stage loads a result.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_leave && !in_action_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_leave && !in_action_reg) begin
            out_color_reg <= shade_color;
            out_src_reg   <= shade_src;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tuser  = out_src_reg;

endmodule
